[design/pbh_pkg.sv]
package pbh_pkg;

    // 64-bit FNV prime: 2^40 + 0x1b3.
    localparam logic [63:0] FNV_PRIME  = 64'h0000_0100_0000_01b3;
    localparam logic [7:0]  SLASH_BYTE = 8'h2F;
    localparam logic [7:0]  DOT_BYTE   = 8'h2E;

    // Value reported when a slash was seen but the name part is empty.
    localparam logic [63:0] INVALID_HASH = 64'd1;

    typedef struct packed {
        logic [7:0] path_byte;
        logic       end_of_path;
    } t_in_word;

    typedef struct packed {
        logic [63:0] name_hash;
        logic        name_invalid;
    } t_out_word;

endpackage

[design/pbh_fnv_mul.sv]
module pbh_fnv_mul
    import pbh_pkg::*;
(
    input  logic [63:0] i_hash,
    input  logic [7:0]  i_byte,
    output logic [63:0] o_hash
);

    // The prime is 2^40 + 2^8 + 2^7 + 2^5 + 2^4 + 2^1 + 2^0, so the product
    // modulo 2^64 is a sum of seven shifted copies of the hash.
    logic [63:0] w_prod;

    assign w_prod = (i_hash << 40) + (i_hash << 8) + (i_hash << 7) + (i_hash << 5)
                  + (i_hash << 4)  + (i_hash << 1) + i_hash;

    assign o_hash = w_prod ^ {56'd0, i_byte};

endmodule

[design/pbh_name_track.sv]
module pbh_name_track
    import pbh_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_word  i_word,
    output t_out_word o_result
);

    logic [63:0] r_running_hash, n_running_hash;
    logic [63:0] r_hash_at_dot, n_hash_at_dot;
    logic        r_slash_seen, n_slash_seen;
    logic        r_dot_seen, n_dot_seen;
    logic        r_segment_nonempty, n_segment_nonempty;
    logic        r_prefix_nonempty, n_prefix_nonempty;

    logic [63:0] w_next_hash;
    logic [63:0] w_name_hash;
    logic        w_name_empty;

    pbh_fnv_mul u_mul (
        .i_hash (r_running_hash),
        .i_byte (i_word.path_byte),
        .o_hash (w_next_hash)
    );

    // The result always reflects the state before the closing word.
    always_comb begin
        w_name_hash  = r_dot_seen ? r_hash_at_dot : r_running_hash;
        w_name_empty = r_dot_seen ? !r_prefix_nonempty : !r_segment_nonempty;
        if (r_slash_seen && w_name_empty) begin
            o_result.name_hash    = INVALID_HASH;
            o_result.name_invalid = 1'b1;
        end else begin
            o_result.name_hash    = w_name_hash;
            o_result.name_invalid = 1'b0;
        end
    end

    always_comb begin
        n_running_hash     = r_running_hash;
        n_hash_at_dot      = r_hash_at_dot;
        n_slash_seen       = r_slash_seen;
        n_dot_seen         = r_dot_seen;
        n_segment_nonempty = r_segment_nonempty;
        n_prefix_nonempty  = r_prefix_nonempty;
        if (i_step) begin
            if (i_word.end_of_path) begin
                n_running_hash     = '0;
                n_hash_at_dot      = '0;
                n_slash_seen       = 1'b0;
                n_dot_seen         = 1'b0;
                n_segment_nonempty = 1'b0;
                n_prefix_nonempty  = 1'b0;
            end else if (i_word.path_byte == SLASH_BYTE) begin
                n_running_hash     = '0;
                n_slash_seen       = 1'b1;
                n_dot_seen         = 1'b0;
                n_segment_nonempty = 1'b0;
            end else begin
                if (i_word.path_byte == DOT_BYTE) begin
                    // Snapshot before the dot itself enters the hash.
                    n_hash_at_dot     = r_running_hash;
                    n_prefix_nonempty = r_segment_nonempty;
                    n_dot_seen        = 1'b1;
                end
                n_running_hash     = w_next_hash;
                n_segment_nonempty = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running_hash     <= '0;
            r_hash_at_dot      <= '0;
            r_slash_seen       <= 1'b0;
            r_dot_seen         <= 1'b0;
            r_segment_nonempty <= 1'b0;
            r_prefix_nonempty  <= 1'b0;
        end else begin
            r_running_hash     <= n_running_hash;
            r_hash_at_dot      <= n_hash_at_dot;
            r_slash_seen       <= n_slash_seen;
            r_dot_seen         <= n_dot_seen;
            r_segment_nonempty <= n_segment_nonempty;
            r_prefix_nonempty  <= n_prefix_nonempty;
        end
    end

endmodule

[design/path_basename_hash.sv]
// Path: a closing word passes through the input register, then its result word is held in
// the output register until taken; a closing word waits while a stalled result is there.
// Throughput: one word per cycle unless a closing word waits; the hash step (a seven-term
// shift-add for the FNV prime plus an XOR) closes the loop on the running hash.
// Reset: i_rst_n is synchronous and active low; it clears all path state and both valids.
module path_basename_hash
    import pbh_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    // Input register: every accepted word lands here first. Path bytes only
    // update the tracker state, so they can move on even while a finished
    // result is still waiting in the output register.
    logic     r_in_valid;
    t_in_word r_in_word;

    // Output register: holds one result word until the consumer takes it.
    logic      r_out_valid;
    t_out_word r_out_word;

    logic      w_out_blocked;
    logic      w_advance;
    logic      w_step;
    logic      w_in_accept;
    t_out_word w_result;

    // The output register cannot take a new result while it holds one that
    // the consumer is stalling.
    assign w_out_blocked = r_out_valid && i_out_stall;

    // A held word advances unless it is a closing word with nowhere to go.
    assign w_advance   = !(r_in_word.end_of_path && w_out_blocked);
    assign w_step      = r_in_valid && w_advance;
    assign o_in_stall  = r_in_valid && !w_advance;
    assign w_in_accept = i_in_valid && !o_in_stall;

    pbh_name_track u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_word   (r_in_word),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_word <= i_in_word;
        end
    end

    // A closing word that steps loads its result; otherwise the register
    // empties once the consumer has taken its word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && r_in_word.end_of_path) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && r_in_word.end_of_path) begin
            r_out_word <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

[tb/tb_path_basename_hash.sv]
`timescale 1ns / 100ps

// Predicts the name-part hash of each path and keeps the words still owed by the block.
class path_name_hasher;
    localparam logic [63:0] HASH_PRIME = 64'h0000_0100_0000_01b3;

    logic [63:0] seg_hash;
    logic [63:0] dot_hash;
    bit          slash_flag;
    bit          dot_flag;
    bit          seg_flag;
    bit          prefix_flag;
    pbh_pkg::t_out_word owed_q[$];
    int unsigned errors;

    function new();
        errors = 0;
        clear_path();
    endfunction

    function void clear_path();
        seg_hash    = '0;
        dot_hash    = '0;
        slash_flag  = 1'b0;
        dot_flag    = 1'b0;
        seg_flag    = 1'b0;
        prefix_flag = 1'b0;
    endfunction

    function int pending();
        return owed_q.size();
    endfunction

    // Called for every input word that the block accepts.
    function void take_word(input pbh_pkg::t_in_word w);
        logic [63:0]        h;
        bit                 empty;
        pbh_pkg::t_out_word r;
        if (w.end_of_path) begin
            if (dot_flag) begin
                h     = dot_hash;
                empty = !prefix_flag;
            end else begin
                h     = seg_hash;
                empty = !seg_flag;
            end
            r.name_invalid = slash_flag && empty;
            r.name_hash    = r.name_invalid ? 64'd1 : h;
            owed_q.push_back(r);
            clear_path();
        end else if (w.path_byte == pbh_pkg::SLASH_BYTE) begin
            seg_hash   = '0;
            slash_flag = 1'b1;
            dot_flag   = 1'b0;
            seg_flag   = 1'b0;
        end else begin
            if (w.path_byte == pbh_pkg::DOT_BYTE) begin
                dot_hash    = seg_hash;
                prefix_flag = seg_flag;
                dot_flag    = 1'b1;
            end
            seg_hash = (seg_hash * HASH_PRIME) ^ {56'd0, w.path_byte};
            seg_flag = 1'b1;
        end
    endfunction

    task report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        errors++;
    endtask

    // Called for every result word that the testbench accepts.
    task check_word(input pbh_pkg::t_out_word got);
        pbh_pkg::t_out_word want;
        if (owed_q.size() == 0) begin
            report_mismatch($sformatf("unexpected word hash=%h invalid=%b",
                                      got.name_hash, got.name_invalid));
            return;
        end
        want = owed_q.pop_front();
        if (got.name_hash !== want.name_hash)
            report_mismatch($sformatf("name_hash %h, expected %h",
                                      got.name_hash, want.name_hash));
        if (got.name_invalid !== want.name_invalid)
            report_mismatch($sformatf("name_invalid %b, expected %b",
                                      got.name_invalid, want.name_invalid));
    endtask
endclass

module tb_path_basename_hash;
    import pbh_pkg::*;

    // Longest receiver hold-off; the block must fill up and stall its input during it.
    localparam int unsigned HOLD_CYCLES    = 300;
    // Cycles without any accepted word before the run is declared hung.
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    // Margin run after the last owed result word has been checked.
    localparam int unsigned DRAIN_CYCLES   = 10;
    localparam int unsigned IDLE_PERCENT   = 7;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;

    // Both sides idle at random while this is set.
    bit          idle_on  = 1'b1;
    // Raised by the stimulus to ask the result side for one long hold-off.
    bit          hold_req = 1'b0;
    int unsigned words_sent = 0;
    int unsigned quiet_cycles = 0;

    path_name_hasher hasher = new();

    path_basename_hash uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Offers one word and returns at the edge where the block takes it. The valid is
    // only lowered for an idle gap, so a word that follows at once keeps it high.
    task automatic send_word(input t_in_word w);
        if (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        hasher.take_word(w);
        words_sent++;
    endtask

    // Sends the characters of a string as path bytes, then a closing word. The byte
    // field of the closing word is random, since the block must ignore it.
    task automatic send_text(input string s);
        t_in_word w;
        for (int k = 0; k < s.len(); k++) begin
            w.path_byte   = s[k];
            w.end_of_path = 1'b0;
            send_word(w);
        end
        w.path_byte   = 8'($urandom);
        w.end_of_path = 1'b1;
        send_word(w);
    endtask

    // Picks one path byte. Dense paths use only slash, dot and one letter, so that
    // runs of separators and empty names come up often; noisy paths use any byte.
    function automatic logic [7:0] pick_byte(input int unsigned style);
        int unsigned r;
        r = $urandom_range(99);
        if (style < 2) begin
            if (r < 35)
                return SLASH_BYTE;
            else if (r < 70)
                return DOT_BYTE;
            else
                return "a";
        end
        if (style == 9)
            return 8'($urandom);
        if (r < 15)
            return SLASH_BYTE;
        else if (r < 30)
            return DOT_BYTE;
        else if (r < 90)
            return 8'("a" + $urandom_range(25));
        else
            return 8'($urandom);
    endfunction

    // One random path of mostly short length, now and then a long one, then its close.
    task automatic send_path();
        int unsigned style;
        int unsigned len;
        t_in_word    w;
        style = $urandom_range(9);
        len   = ($urandom_range(19) == 0) ? $urandom_range(64) : $urandom_range(12);
        for (int k = 0; k < len; k++) begin
            w.path_byte   = pick_byte(style);
            w.end_of_path = 1'b0;
            send_word(w);
        end
        w.path_byte   = 8'($urandom);
        w.end_of_path = 1'b1;
        send_word(w);
    endtask

    // Result side: checks every accepted word, then chooses the stall for the next
    // cycle. A requested hold-off is counted down here, independent of the sender.
    initial begin : result_sink
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                hasher.check_word(out_word);
            if (hold_left != 0) begin
                hold_left--;
            end else if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            out_stall <= (hold_left != 0) ||
                         (idle_on && $urandom_range(99) < IDLE_PERCENT);
        end
    end

    // Any accepted word on either side restarts the count of quiet cycles.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : path_source
        t_in_word w;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed paths. An empty path gives hash zero without the invalid flag,
        // and so does a name that is only an extension with no slash in front.
        send_text("");
        send_text(".b");
        // A slash followed by an empty name, bare or before an extension, is invalid.
        send_text("/");
        send_text("a/.x");
        // The extreme byte values hash like any other byte.
        w.end_of_path = 1'b0;
        w.path_byte   = 8'hFF;
        send_word(w);
        w.path_byte   = 8'h00;
        send_word(w);
        send_text("");
        // Only the last dot after the last slash ends the name.
        send_text("/a.b.c");
        send_text("a.");

        // Random paths with idling on both sides.
        while (words_sent < 700) send_path();
        // A long stretch at full rate on both sides.
        idle_on = 1'b0;
        while (words_sent < 1300) send_path();
        // The result side holds off while paths keep coming, so the block backs up.
        idle_on  = 1'b1;
        hold_req = 1'b1;
        while (words_sent < 1850) send_path();
        in_valid <= 1'b0;

        while (hasher.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (hasher.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

[sim.f]
design/pbh_pkg.sv
design/pbh_fnv_mul.sv
design/pbh_name_track.sv
design/path_basename_hash.sv
tb/tb_path_basename_hash.sv
